// ===== sv/mrfr_pkg.sv =====
// Package: shared types, codes and constants of the meter reply frame receiver.
package mrfr_pkg;

    localparam int ADDRESS_BYTES_DEFAULT = 7;

    localparam logic [7:0] START_BYTE         = 8'h68;
    localparam logic [7:0] DEVICE_BYTE        = 8'h10;
    localparam logic [7:0] CONTROL_BYTE       = 8'h81;
    localparam logic [7:0] DEFAULT_MAX_LENGTH = 8'h60;
    localparam logic [7:0] END_BYTE           = 8'h16;

    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_METER_ADDRESS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_LENGTH    = 1'b1;

    typedef enum logic [7:0] {
        PH_START   = 8'b0000_0001,
        PH_DEVICE  = 8'b0000_0010,
        PH_ADDR    = 8'b0000_0100,
        PH_CONTROL = 8'b0000_1000,
        PH_LENGTH  = 8'b0001_0000,
        PH_DATA    = 8'b0010_0000,
        PH_CHECK   = 8'b0100_0000,
        PH_END     = 8'b1000_0000
    } phase_t;

    typedef enum logic [3:0] {
        ST_IN_PROGRESS  = 4'd0,
        ST_FRAME_OK     = 4'd1,
        ST_BAD_START    = 4'd2,
        ST_BAD_DEVICE   = 4'd3,
        ST_ADDR_MISMATCH = 4'd4,
        ST_BAD_CONTROL  = 4'd5,
        ST_BAD_LENGTH   = 4'd6,
        ST_BAD_CHECKSUM = 4'd7,
        ST_BAD_END      = 4'd8
    } status_t;

    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_ID_LOW  = 3'd1,
        KIND_ID_HIGH = 3'd2,
        KIND_SERIAL  = 3'd3,
        KIND_PAYLOAD = 3'd4
    } kind_t;

    typedef struct packed {
        status_t    status;
        kind_t      field_kind;
        logic [7:0] field_byte;
        logic [7:0] payload_index;
        logic [7:0] frame_len;
    } result_t;

endpackage

// ===== sv/mrfr_ifs.sv =====
// Interfaces: received byte channel and result channel.
interface mrfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mrfr_result_if;
    logic       valid;
    logic       ready;
    logic [3:0] status;
    logic [2:0] field_kind;
    logic [7:0] field_byte;
    logic [7:0] payload_index;
    logic [7:0] frame_len;

    modport source (output valid, output status, output field_kind, output field_byte,
                    output payload_index, output frame_len, input ready);
    modport sink   (input valid, input status, input field_kind, input field_byte,
                    input payload_index, input frame_len, output ready);
endinterface

// ===== sv/mrfr_cfg_regs.sv =====
// Configuration registers: meter address and length limit.
module mrfr_cfg_regs #(
    parameter int ADDRESS_BYTES = mrfr_pkg::ADDRESS_BYTES_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mrfr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [8*ADDRESS_BYTES-1:0]          cfg_data,
    output logic [8*ADDRESS_BYTES-1:0]          meter_address,
    output logic [7:0]                          max_length
);

    logic [8*ADDRESS_BYTES-1:0] meter_address_reg;
    logic [7:0]                 max_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meter_address_reg <= '0;
            max_length_reg    <= mrfr_pkg::DEFAULT_MAX_LENGTH;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mrfr_pkg::REG_METER_ADDRESS: meter_address_reg <= cfg_data;
                mrfr_pkg::REG_MAX_LENGTH:    max_length_reg    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign meter_address = meter_address_reg;
    assign max_length    = max_length_reg;

endmodule

// ===== sv/mrfr_in_stage.sv =====
// Input register: holds one received byte until the parser takes it.
module mrfr_in_stage (
    input  logic         clk,
    input  logic         rst_n,
    mrfr_byte_if.sink    rx,
    input  logic         advance,
    output logic         hold_valid,
    output logic [7:0]   hold_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       take;

    assign rx.ready   = !valid_reg || advance;
    assign take       = rx.valid && rx.ready;
    assign valid_next = take ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= rx.rx_byte;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_byte  = byte_reg;

endmodule

// ===== sv/mrfr_parser.sv =====
// Frame parser: phase, counter, checksum and length state plus per-byte decode.
module mrfr_parser #(
    parameter int ADDRESS_BYTES = mrfr_pkg::ADDRESS_BYTES_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic [7:0]                   rx_byte,
    input  logic [8*ADDRESS_BYTES-1:0]   meter_address,
    input  logic [7:0]                   max_length,
    output mrfr_pkg::result_t            result
);

    localparam int IDX_W = (ADDRESS_BYTES > 1) ? $clog2(ADDRESS_BYTES) : 1;

    mrfr_pkg::phase_t  phase_reg, phase_next;
    logic [7:0]        count_reg, count_next;
    logic [7:0]        sum_reg, sum_next;
    logic [7:0]        len_reg, len_next;

    logic [7:0]        addr_bytes [ADDRESS_BYTES];
    logic [7:0]        count_dec;
    logic [7:0]        count_inc;
    logic [7:0]        sum_add;
    logic [IDX_W-1:0]  addr_idx;
    mrfr_pkg::status_t st;

    for (genvar g = 0; g < ADDRESS_BYTES; g++)
    begin : g_addr
        assign addr_bytes[g] = meter_address[8*g +: 8];
    end

    assign count_dec = count_reg - 8'd1;
    assign count_inc = count_reg + 8'd1;
    assign sum_add   = sum_reg + rx_byte;
    assign addr_idx  = count_dec[IDX_W-1:0];

    always_comb
    begin
        phase_next           = phase_reg;
        count_next           = count_reg;
        sum_next             = sum_reg;
        len_next             = len_reg;
        st                   = mrfr_pkg::ST_IN_PROGRESS;
        result.field_kind    = mrfr_pkg::KIND_NONE;
        result.field_byte    = 8'd0;
        result.payload_index = 8'd0;

        case (phase_reg)
            mrfr_pkg::PH_START:
            begin
                if (rx_byte != mrfr_pkg::START_BYTE)
                begin
                    st = mrfr_pkg::ST_BAD_START;
                end
                else
                begin
                    sum_next   = rx_byte;
                    len_next   = 8'd0;
                    count_next = 8'(ADDRESS_BYTES);
                    phase_next = mrfr_pkg::PH_DEVICE;
                end
            end
            mrfr_pkg::PH_DEVICE:
            begin
                if (rx_byte != mrfr_pkg::DEVICE_BYTE)
                begin
                    st = mrfr_pkg::ST_BAD_DEVICE;
                end
                else
                begin
                    sum_next   = sum_add;
                    phase_next = mrfr_pkg::PH_ADDR;
                end
            end
            mrfr_pkg::PH_ADDR:
            begin
                if (rx_byte != addr_bytes[addr_idx])
                begin
                    st = mrfr_pkg::ST_ADDR_MISMATCH;
                end
                else
                begin
                    sum_next   = sum_add;
                    count_next = count_dec;
                    if (count_dec == 8'd0)
                    begin
                        phase_next = mrfr_pkg::PH_CONTROL;
                    end
                end
            end
            mrfr_pkg::PH_CONTROL:
            begin
                if (rx_byte != mrfr_pkg::CONTROL_BYTE)
                begin
                    st = mrfr_pkg::ST_BAD_CONTROL;
                end
                else
                begin
                    sum_next   = sum_add;
                    phase_next = mrfr_pkg::PH_LENGTH;
                end
            end
            mrfr_pkg::PH_LENGTH:
            begin
                if (rx_byte == 8'd0 || rx_byte > max_length)
                begin
                    st = mrfr_pkg::ST_BAD_LENGTH;
                end
                else
                begin
                    sum_next   = sum_add;
                    len_next   = rx_byte;
                    count_next = 8'd0;
                    phase_next = mrfr_pkg::PH_DATA;
                end
            end
            mrfr_pkg::PH_DATA:
            begin
                sum_next          = sum_add;
                result.field_byte = rx_byte;
                if (count_reg < 8'd3)
                begin
                    result.field_kind = mrfr_pkg::kind_t'(3'(count_reg[1:0]) + 3'd1);
                end
                else
                begin
                    result.field_kind    = mrfr_pkg::KIND_PAYLOAD;
                    result.payload_index = count_reg - 8'd3;
                end
                count_next = count_inc;
                if (count_inc == len_reg)
                begin
                    phase_next = mrfr_pkg::PH_CHECK;
                end
            end
            mrfr_pkg::PH_CHECK:
            begin
                if (rx_byte != sum_reg)
                begin
                    st = mrfr_pkg::ST_BAD_CHECKSUM;
                end
                else
                begin
                    phase_next = mrfr_pkg::PH_END;
                end
            end
            mrfr_pkg::PH_END:
            begin
                st = (rx_byte != mrfr_pkg::END_BYTE) ? mrfr_pkg::ST_BAD_END
                                                      : mrfr_pkg::ST_FRAME_OK;
            end
            default:
            begin
                phase_next = mrfr_pkg::PH_START;
            end
        endcase

        // length reported is the one in force for this beat, before any clear
        result.status    = st;
        result.frame_len = len_next;

        if (st != mrfr_pkg::ST_IN_PROGRESS)
        begin
            phase_next = mrfr_pkg::PH_START;
            count_next = 8'd0;
            sum_next   = 8'd0;
            len_next   = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= mrfr_pkg::PH_START;
            count_reg <= 8'd0;
            sum_reg   <= 8'd0;
            len_reg   <= 8'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            len_reg   <= len_next;
        end
    end

endmodule

// ===== sv/mrfr_out_stage.sv =====
// Result register: holds one result beat until the sink takes it.
module mrfr_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  mrfr_pkg::result_t result_next,
    output logic              free,
    mrfr_result_if.source     res
);

    logic              valid_reg;
    logic              valid_next;
    mrfr_pkg::result_t result_reg;

    assign free       = !valid_reg || res.ready;
    assign valid_next = load ? 1'b1 : (res.ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_next;
        end
    end

    assign res.valid         = valid_reg;
    assign res.status        = result_reg.status;
    assign res.field_kind    = result_reg.field_kind;
    assign res.field_byte    = result_reg.field_byte;
    assign res.payload_index = result_reg.payload_index;
    assign res.frame_len     = result_reg.frame_len;

endmodule

// ===== sv/meter_reply_frame_receiver_top.sv =====
// Top level: meter reply frame receiver, one result beat per received byte.
// A byte in the input register is decoded by the parser, and its result beat is registered in the result register.
// Throughput: one byte per cycle while the result sink keeps taking beats; set by the single
//   parser step between the input register and the result register.
// Reset (rst_n low, async): parser hunts for a start byte, all counters and the
//   checksum clear, both stages empty, meter_address = 0, max_length = 0x60.
module meter_reply_frame_receiver_top #(
    parameter int ADDRESS_BYTES = mrfr_pkg::ADDRESS_BYTES_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    mrfr_byte_if.sink                         rx,
    mrfr_result_if.source                     res,
    input  logic                              cfg_we,
    input  logic [mrfr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [8*ADDRESS_BYTES-1:0]        cfg_data
);

    // Pipeline:
    //   rx beat -> input register -> parser (state update) -> result register -> res beat
    // The parser steps whenever the input register holds a byte and the result
    // register is empty or being drained the same cycle; the input register in
    // turn refills in that same cycle, so bytes stream with no bubbles.

    logic [8*ADDRESS_BYTES-1:0] meter_address;
    logic [7:0]                 max_length;
    logic                       hold_valid;
    logic [7:0]                 hold_byte;
    logic                       out_free;
    logic                       advance;
    mrfr_pkg::result_t          parse_result;

    assign advance = hold_valid && out_free;

    mrfr_cfg_regs #(
        .ADDRESS_BYTES (ADDRESS_BYTES)
    ) u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .meter_address (meter_address),
        .max_length    (max_length)
    );

    mrfr_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .advance    (advance),
        .hold_valid (hold_valid),
        .hold_byte  (hold_byte)
    );

    // Parser state (phase, address/data counter, checksum, length) moves only
    // on a step, so a stalled result side freezes the frame in place.
    mrfr_parser #(
        .ADDRESS_BYTES (ADDRESS_BYTES)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .rx_byte       (hold_byte),
        .meter_address (meter_address),
        .max_length    (max_length),
        .result        (parse_result)
    );

    mrfr_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance),
        .result_next (parse_result),
        .free        (out_free),
        .res         (res)
    );

    // A data field is only ever reported while the frame is still in progress.
    a_field_in_progress: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.field_kind != mrfr_pkg::KIND_NONE
        |-> res.status == mrfr_pkg::ST_IN_PROGRESS)
        else $error("data field reported with a final status");

    // A data field implies an accepted, nonzero length.
    a_field_has_length: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.field_kind != mrfr_pkg::KIND_NONE
        |-> res.frame_len != 8'd0)
        else $error("data field without an accepted length");

    // Payload position stays inside the declared length.
    a_payload_bound: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.field_kind == mrfr_pkg::KIND_PAYLOAD
        |-> res.payload_index < res.frame_len)
        else $error("payload index beyond frame length");

    // The parser never steps on an empty input register.
    a_step_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> hold_valid && out_free)
        else $error("parser stepped without a held byte");

endmodule
